[hw/rtl/crc32rb_pkg.sv]
// Shared types, constants and remainder table for the reflected CRC-32 block.
package crc32rb_pkg;

	localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
	localparam logic [31:0] CRC_ALL_ONES = 32'hFFFFFFFF;
	localparam int unsigned TABLE_DEPTH  = 256;

	localparam int unsigned IN_QUEUE_DEPTH  = 4;
	localparam int unsigned OUT_QUEUE_DEPTH = 2;

	// Item class, decided by the front from the message flags
	typedef enum logic [1:0] {
		OP_CONT   = 2'b00,
		OP_START  = 2'b01,
		OP_END    = 2'b10,
		OP_SINGLE = 2'b11
	} op_t;

	// Classified item carried from front to back
	typedef struct packed {
		logic [7:0] data;
		op_t        op;
	} item_t;

	typedef logic [31:0] crc_table_t [TABLE_DEPTH];

	// Divide one byte value bitwise over eight steps by the reflected polynomial
	function automatic logic [31:0] divide_byte(input logic [7:0] value);
		logic [31:0] v;
		v = {24'h000000, value};
		for (int k = 0; k < 8; k++) begin
			if (v[0]) begin
				v = (v >> 1) ^ CRC_POLY;
			end else begin
				v = v >> 1;
			end
		end
		return v;
	endfunction

	function automatic crc_table_t build_table();
		crc_table_t t;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			t[i] = divide_byte(i[7:0]);
		end
		return t;
	endfunction

	localparam crc_table_t REM_TABLE = build_table();

endpackage

[hw/rtl/crc32rb_fifo.sv]
// Small register queue with full and empty flags.
module crc32rb_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the item
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[hw/rtl/crc32rb_front.sv]
// Front end: accepts bytes, classifies them by message position and queues them.
module crc32rb_front #(
	parameter int unsigned DEPTH = crc32rb_pkg::IN_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [7:0]          data_byte,
	input  logic                first_byte,
	input  logic                last_byte,
	input  logic                item_pop,
	output crc32rb_pkg::item_t  item,
	output logic                item_empty
);

	import crc32rb_pkg::*;

	item_t in_item;

	// Classify the byte by its flags
	always_comb begin
		in_item.data = data_byte;
		unique case ({last_byte, first_byte})
			2'b00:   in_item.op = OP_CONT;
			2'b01:   in_item.op = OP_START;
			2'b10:   in_item.op = OP_END;
			default: in_item.op = OP_SINGLE;
		endcase
	end

	// Hold classified items until the back end takes them
	crc32rb_fifo #(
		.WIDTH ($bits(item_t)),
		.DEPTH (DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (in_item),
		.full   (full),
		.pop    (item_pop),
		.rdata  (item),
		.empty  (item_empty)
	);

endmodule

[hw/rtl/crc32rb_back.sv]
// Back end: folds each queued byte into the running CRC and queues final values.
module crc32rb_back #(
	parameter int unsigned DEPTH = crc32rb_pkg::OUT_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  crc32rb_pkg::item_t  item,
	input  logic                item_empty,
	output logic                item_pop,
	output logic                empty,
	input  logic                pop,
	output logic [31:0]         crc_value
);

	import crc32rb_pkg::*;

	logic [31:0] crc_q;
	logic [31:0] crc_base;
	logic [31:0] crc_next;
	logic        is_first;
	logic        is_last;
	logic        res_full;
	logic        res_push;

	// Decode the item class
	always_comb begin
		unique case (item.op)
			OP_CONT: begin
				is_first = 1'b0;
				is_last  = 1'b0;
			end
			OP_START: begin
				is_first = 1'b1;
				is_last  = 1'b0;
			end
			OP_END: begin
				is_first = 1'b0;
				is_last  = 1'b1;
			end
			default: begin
				is_first = 1'b1;
				is_last  = 1'b1;
			end
		endcase
	end

	// Take an item whenever the result queue has room
	assign item_pop = !item_empty && !res_full;
	assign res_push = item_pop && is_last;

	// Table step: shift out one byte and fold in its remainder
	assign crc_base = is_first ? CRC_ALL_ONES : crc_q;
	assign crc_next = (crc_base >> 8) ^ REM_TABLE[item.data ^ crc_base[7:0]];

	// Update the running CRC; reload all ones after a last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_ALL_ONES;
		end else if (item_pop) begin
			crc_q <= is_last ? CRC_ALL_ONES : crc_next;
		end
	end

	// Hold final CRCs until taken
	crc32rb_fifo #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_result (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (crc_next ^ CRC_ALL_ONES),
		.full   (res_full),
		.pop    (pop),
		.rdata  (crc_value),
		.empty  (empty)
	);

endmodule

[hw/rtl/crc32_reflected_byte_table.sv]
// CRC-32 (reflected, poly 0xEDB88320) over a byte stream, one byte per cycle
//   while the result queue has room, set by the single table step in the back end.
// Path: a last byte is written into the front queue, then its table step writes the
//   final CRC into the result queue, which drives crc_value; items already queued or
//   pop held low delay it.
// Reset: arst_n clears both queues and loads the running CRC with all ones.
module crc32_reflected_byte_table #(
	parameter int unsigned IN_DEPTH  = crc32rb_pkg::IN_QUEUE_DEPTH,
	parameter int unsigned OUT_DEPTH = crc32rb_pkg::OUT_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        last_byte,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] crc_value
);

	import crc32rb_pkg::*;

	item_t item;
	logic  item_empty;
	logic  item_pop;

	crc32rb_front #(
		.DEPTH (IN_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.last_byte  (last_byte),
		.item_pop   (item_pop),
		.item       (item),
		.item_empty (item_empty)
	);

	crc32rb_back #(
		.DEPTH (OUT_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_empty (item_empty),
		.item_pop   (item_pop),
		.empty      (empty),
		.pop        (pop),
		.crc_value  (crc_value)
	);

endmodule

[hw/rtl/crc32rb_checker.sv]
// Port-level checks for the CRC-32 block, bound to the top level.
module crc32rb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [31:0] crc_value
);

	// A waiting result holds until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(crc_value))
		else $error("result changed while waiting");

	// The input side fills only after a push
	a_full_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a push");

	// The result side drains only after a pop
	a_empty_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(empty) |-> $past(pop))
		else $error("empty rose without a pop");

endmodule

bind crc32_reflected_byte_table crc32rb_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.push      (push),
	.full      (full),
	.empty     (empty),
	.pop       (pop),
	.crc_value (crc_value)
);

[dv/crc32_reflected_byte_table_test.sv]
// Testbench for the byte-wise reflected CRC-32 block: stimulus, predictor and result checks.
`timescale 1ns / 1ps

module crc32_reflected_byte_table_test;
	import crc32rb_pkg::*;

	localparam int RANDOM_BYTES   = 1225;
	localparam int HOLD_AT_BYTE   = 400;
	localparam int DRAIN_AT_BYTE  = 800;
	localparam int HOLD_CYCLES    = 80;
	localparam int HOLD_MESSAGES  = 24;
	localparam int SETTLE_CYCLES  = 8;
	localparam int PATTERN_CYCLES = 48;

	// Receiver stall pattern kinds
	localparam int RX_STREAM = 0;
	localparam int RX_RANDOM = 1;
	localparam int RX_SPARSE = 2;
	localparam int RX_BURSTY = 3;

	// Random message shapes
	localparam int MSG_CLEAN      = 0;
	localparam int MSG_NO_FIRST   = 1;
	localparam int MSG_RESTART    = 2;
	localparam int MSG_OPEN_ENDED = 3;

	typedef struct packed {
		logic [7:0]  data;
		logic        first;
		logic        last;
		logic        typed;
		logic [31:0] crc;
	} stim_row_t;

	// Hand-checked rows carry a typed CRC; the rest go through the predictor
	localparam int DIRECTED_COUNT = 26;
	localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		'{8'h00, 1'b0, 1'b1, 1'b1, 32'hD202EF8D},
		'{8'hFF, 1'b0, 1'b1, 1'b1, 32'hFF000000},
		'{8'hFF, 1'b1, 1'b1, 1'b1, 32'hFF000000},
		'{8'h31, 1'b1, 1'b0, 1'b0, 32'h00000000},
		'{8'h32, 1'b0, 1'b0, 1'b0, 32'h00000000},
		'{8'h33, 1'b0, 1'b0, 1'b0, 32'h00000000},
		'{8'h34, 1'b0, 1'b0, 1'b0, 32'h00000000},
		'{8'h35, 1'b0, 1'b0, 1'b0, 32'h00000000},
		'{8'h36, 1'b0, 1'b0, 1'b0, 32'h00000000},
		'{8'h37, 1'b0, 1'b0, 1'b0, 32'h00000000},
		'{8'h38, 1'b0, 1'b0, 1'b0, 32'h00000000},
		'{8'h39, 1'b0, 1'b1, 1'b1, 32'hCBF43926},
		'{8'hFF, 1'b1, 1'b0, 1'b0, 32'h00000000},
		'{8'hFF, 1'b0, 1'b0, 1'b0, 32'h00000000},
		'{8'hFF, 1'b0, 1'b0, 1'b0, 32'h00000000},
		'{8'hFF, 1'b0, 1'b1, 1'b1, 32'hFFFFFFFF},
		'{8'h00, 1'b1, 1'b0, 1'b0, 32'h00000000},
		'{8'h00, 1'b0, 1'b0, 1'b0, 32'h00000000},
		'{8'h00, 1'b0, 1'b0, 1'b0, 32'h00000000},
		'{8'h00, 1'b0, 1'b1, 1'b1, 32'h2144DF1C},
		'{8'hA5, 1'b1, 1'b0, 1'b0, 32'h00000000},
		'{8'h5A, 1'b0, 1'b0, 1'b0, 32'h00000000},
		'{8'h3C, 1'b1, 1'b0, 1'b0, 32'h00000000},
		'{8'hC3, 1'b0, 1'b1, 1'b0, 32'h00000000},
		'{8'h80, 1'b1, 1'b1, 1'b0, 32'h00000000},
		'{8'h01, 1'b0, 1'b1, 1'b0, 32'h00000000}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  data_byte = 8'h00;
	logic        first_byte = 1'b0;
	logic        last_byte = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [31:0] crc_value;

	// Predictor state and the store of CRCs still owed by the block
	logic [31:0] crc_lut [TABLE_DEPTH];
	logic [31:0] crc_run;
	logic [31:0] pending_crcs [$];
	stim_row_t   hand_checked [$];

	int mismatches = 0;
	int bytes_taken = 0;
	int crcs_checked = 0;
	int backpressure_cycles = 0;
	int burst_left = 0;
	bit no_gaps = 1'b0;

	logic hold_req = 1'b0;
	logic hold_seen;
	int   hold_left;
	logic [15:0] rx_pattern;
	int   rx_age;

	crc32_reflected_byte_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.first_byte(first_byte),
		.last_byte(last_byte),
		.empty(empty),
		.pop(pop),
		.crc_value(crc_value)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Remainder of one index after eight shift-and-reduce steps
	function automatic logic [31:0] remainder_of(input int idx);
		logic [31:0] r;
		r = idx;
		repeat (8) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			crc_lut[i] = remainder_of(i);
		end
	end

	// Check each popped CRC, predict each accepted byte
	always @(posedge clk) begin
		logic [31:0] seed;
		logic [31:0] folded;
		logic [31:0] owed;
		stim_row_t   row;
		if (!arst_n) begin
			crc_run = CRC_ALL_ONES;
		end else begin
			if (pop && !empty) begin
				if (pending_crcs.size() == 0) begin
					$display("%0t: unexpected result crc_value %08h", $time, crc_value);
					mismatches++;
				end else begin
					owed = pending_crcs.pop_front();
					if (crc_value !== owed) begin
						$display("%0t: crc_value mismatch: expected %08h, actual %08h",
							$time, owed, crc_value);
						mismatches++;
					end
					crcs_checked++;
				end
			end
			if (push && full) begin
				backpressure_cycles++;
			end
			if (push && !full) begin
				bytes_taken++;
				row = '0;
				if (hand_checked.size() != 0) begin
					row = hand_checked.pop_front();
				end
				seed = first_byte ? CRC_ALL_ONES : crc_run;
				folded = (seed >> 8) ^ crc_lut[seed[7:0] ^ data_byte];
				if (last_byte) begin
					pending_crcs.push_back(row.typed ? row.crc : (folded ^ CRC_ALL_ONES));
					crc_run = CRC_ALL_ONES;
				end else begin
					crc_run = folded;
				end
			end
		end
	end

	// Receiver: rotate a stall pattern, reload it now and then, hold off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			hold_seen <= 1'b0;
			hold_left <= 0;
			rx_pattern <= 16'hFFFF;
			rx_age <= 0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			pop <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			pop <= 1'b0;
		end else if (rx_age == 0) begin
			rx_age <= PATTERN_CYCLES;
			case ($urandom_range(RX_STREAM, RX_BURSTY))
				RX_STREAM: rx_pattern <= 16'hFFFF;
				RX_RANDOM: rx_pattern <= 16'($urandom());
				RX_SPARSE: rx_pattern <= 16'($urandom() & $urandom());
				default:   rx_pattern <= 16'hFF00 >> $urandom_range(0, 7);
			endcase
			pop <= 1'b0;
		end else begin
			rx_age <= rx_age - 1;
			pop <= rx_pattern[0];
			rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
		end
	end

	// Idle between bursts; lower push only when a gap follows
	task automatic take_gap();
		int gap;
		if (!no_gaps) begin
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap != 0) begin
					push <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	endtask

	// Offer one item and hold it until the block takes it
	task automatic offer_byte(input logic [7:0] b, input logic f, input logic l);
		push <= 1'b1;
		data_byte <= b;
		first_byte <= f;
		last_byte <= l;
		@(posedge clk);
		while (full) @(posedge clk);
		take_gap();
	endtask

	task automatic wait_all_crcs();
		push <= 1'b0;
		@(negedge clk);
		while (pending_crcs.size() != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// Mostly clean messages with random bytes, some with broken framing
	task automatic send_message(output int sent);
		int len;
		int shape;
		int restart_at;
		logic f;
		logic l;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
		shape = $urandom_range(0, 99);
		if (shape < 80) shape = MSG_CLEAN;
		else if (shape < 88) shape = MSG_NO_FIRST;
		else if (shape < 94) shape = MSG_RESTART;
		else shape = MSG_OPEN_ENDED;
		restart_at = $urandom_range(0, len - 1);
		for (int i = 0; i < len; i++) begin
			f = (i == 0 && shape != MSG_NO_FIRST) || (shape == MSG_RESTART && i == restart_at);
			l = (i == len - 1) && shape != MSG_OPEN_ENDED;
			offer_byte(8'($urandom_range(0, 255)), f, l);
		end
		sent = len;
	endtask

	initial begin
		int sent;
		int random_sent;
		bit hold_done;
		bit drain_done;
		random_sent = 0;
		hold_done = 1'b0;
		drain_done = 1'b0;
		for (int i = 0; i < DIRECTED_COUNT; i++) begin
			hand_checked.push_back(DIRECTED_ROWS[i]);
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed rows
		for (int i = 0; i < DIRECTED_COUNT; i++) begin
			offer_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].first, DIRECTED_ROWS[i].last);
		end

		// Random messages, with one long receiver hold-off and one full drain
		while (random_sent < RANDOM_BYTES) begin
			if (!hold_done && random_sent >= HOLD_AT_BYTE) begin
				hold_done = 1'b1;
				hold_req <= ~hold_req;
				no_gaps = 1'b1;
				for (int m = 0; m < HOLD_MESSAGES; m++) begin
					offer_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1);
				end
				no_gaps = 1'b0;
				random_sent += HOLD_MESSAGES;
			end
			if (!drain_done && random_sent >= DRAIN_AT_BYTE) begin
				drain_done = 1'b1;
				wait_all_crcs();
			end
			send_message(sent);
			random_sent += sent;
		end

		wait_all_crcs();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_crcs.size() != 0) begin
			$display("%0t: %0d CRC results never arrived", $time, pending_crcs.size());
			mismatches++;
		end
		$display("Fed %0d bytes, checked %0d message CRCs; input stalled on %0d cycles.",
			bytes_taken, crcs_checked, backpressure_cycles);
		if (mismatches == 0) begin
			$display("crc32_reflected_byte_table test passed");
		end else begin
			$display("crc32_reflected_byte_table test failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("%0t: watchdog expired with %0d CRCs outstanding", $time, pending_crcs.size());
		$display("crc32_reflected_byte_table test failed");
		$finish;
	end

endmodule
